// ----- rtl/core/sparse_squared_distance_macros.svh -----
// assertion macros used by the sparse squared distance controller
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SPARSE_SQUARED_DISTANCE_MACROS_SVH
`define SPARSE_SQUARED_DISTANCE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ssd_pkg.sv -----
// package for the sparse squared distance block: request and result types,
// command codes, controller to datapath command and status structs; no dependencies
`timescale 1ns / 1ps

package ssd_pkg;

  // default sizing
  localparam int unsigned MaxEntriesDef = 256;
  localparam int unsigned IndexBitsDef  = 24;

  // command codes of a request
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_B_ITEM = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // saturation limits
  localparam logic [62:0] DIST_MAX = {63{1'b1}};
  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

  // one request
  typedef struct packed {
    logic [1:0]         cmd;
    logic [23:0]        feature_idx;
    logic signed [31:0] entry_value;
    logic [61:0]        sq_norm_a;
    logic [61:0]        sq_norm_b;
  } ssd_req_t;

  // one result
  typedef struct packed {
    logic [62:0] distance;
    logic        overflow;
  } ssd_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic wr_en;      // store request entry at the write address
    logic rd_en;      // read the A buffer at the read address
    logic latch_b;    // capture the B entry
    logic latch_tot;  // capture the sum of both norms
    logic mul_en;     // register the product of A and B values
    logic acc_en;     // saturating add of the product into the sum
    logic diff_en;    // register total minus twice the sum
    logic out_en;     // register the clamped result and strobe it
    logic clear;      // clear sum and overflow flag
    logic set_ovf;    // A entry dropped
  } ssd_dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_lt;     // buffered A index below the B index
    logic idx_eq;     // buffered A index equals the B index
  } ssd_dp_sts_t;

endpackage

// ----- rtl/core/ssd_datapath.sv -----
// datapath of the sparse squared distance block: A buffer memory, multiplier,
// saturating accumulator and distance stages; depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_datapath #(
  parameter int unsigned MAX_ENTRIES = ssd_pkg::MaxEntriesDef,
  parameter int unsigned INDEX_BITS  = ssd_pkg::IndexBitsDef,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssd_pkg::ssd_req_t    req_i,
  input  ssd_pkg::ssd_dp_cmd_t cmd_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [AW-1:0]        rd_addr_i,
  output ssd_pkg::ssd_dp_sts_t sts_o,
  output logic                 done_o,
  output ssd_pkg::ssd_rsp_t    rsp_o
);
  import ssd_pkg::*;

  logic [INDEX_BITS-1:0] idx_mem [MAX_ENTRIES];
  logic signed [31:0]    val_mem [MAX_ENTRIES];

  logic [INDEX_BITS-1:0] req_idx;
  logic [INDEX_BITS-1:0] rd_idx_q, b_idx_q;
  logic signed [31:0]    rd_val_q, b_val_q;
  logic signed [63:0]    prod_d, prod_q;
  logic signed [63:0]    sum_q, sum_d;
  logic [64:0]           sum_ext;
  logic                  sum_sat;
  logic                  ovf_q, ovf_d;
  logic [62:0]           total_q;
  logic [65:0]           diff_d, diff_q;
  logic [65:0]           mag;
  logic [62:0]           dist_d;
  logic                  done_q;
  ssd_rsp_t              rsp_q;

  // only the low index bits take part
  assign req_idx = INDEX_BITS'(req_i.feature_idx);

  // A buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      idx_mem[wr_addr_i] <= req_idx;
      val_mem[wr_addr_i] <= req_i.entry_value;
    end
    if (cmd_i.rd_en) begin
      rd_idx_q <= idx_mem[rd_addr_i];
      rd_val_q <= val_mem[rd_addr_i];
    end
  end

  // index compare for the merge
  assign sts_o.idx_lt = rd_idx_q < b_idx_q;
  assign sts_o.idx_eq = rd_idx_q == b_idx_q;

  // exact signed product of two q16.16 values
  assign prod_d = rd_val_q * b_val_q;

  // payload captures
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_b) begin
      b_idx_q <= req_idx;
      b_val_q <= req_i.entry_value;
    end
    if (cmd_i.latch_tot) begin
      total_q <= {1'b0, req_i.sq_norm_a} + {1'b0, req_i.sq_norm_b};
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.diff_en) begin
      diff_q <= diff_d;
    end
    if (cmd_i.out_en) begin
      rsp_q.distance <= dist_d;
      rsp_q.overflow <= ovf_q;
    end
  end

  // saturating accumulate and overflow flag
  assign sum_ext = {sum_q[63], sum_q} + {prod_q[63], prod_q};
  assign sum_sat = sum_ext[64] != sum_ext[63];

  always_comb begin
    sum_d = sum_q;
    ovf_d = ovf_q;
    if (cmd_i.clear) begin
      sum_d = '0;
      ovf_d = 1'b0;
    end else begin
      if (cmd_i.acc_en) begin
        if (sum_sat) begin
          sum_d = sum_ext[64] ? SUM_MIN : SUM_MAX;
          ovf_d = 1'b1;
        end else begin
          sum_d = sum_ext[63:0];
        end
      end
      if (cmd_i.set_ovf) begin
        ovf_d = 1'b1;
      end
    end
  end

  // total minus twice the sum, then magnitude clamped to 63 bits
  assign diff_d = {3'b000, total_q} - {sum_q[63], sum_q, 1'b0};
  assign mag    = diff_q[65] ? (66'd0 - diff_q) : diff_q;
  assign dist_d = (|mag[65:63]) ? DIST_MAX : mag[62:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      ovf_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      ovf_q  <= ovf_d;
      done_q <= cmd_i.out_en;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- rtl/core/ssd_ctrl.sv -----
// controller of the sparse squared distance block: request decode, buffer
// count, merge pointer and sequencing; depends on ssd_pkg and the macro header
`timescale 1ns / 1ps

module ssd_ctrl #(
  parameter int unsigned MAX_ENTRIES = ssd_pkg::MaxEntriesDef,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           cmd_i,
  output logic                 busy_o,
  input  ssd_pkg::ssd_dp_sts_t sts_i,
  output ssd_pkg::ssd_dp_cmd_t dp_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic [AW-1:0]        rd_addr_o
);
  import ssd_pkg::*;
  `include "sparse_squared_distance_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] ptr_inc;
  logic          rd_next;
  logic          accept;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign busy_o  = state_q != ST_IDLE;
  assign ptr_inc = ptr_q + 1'b1;

  assign wr_addr_o = cnt_q[AW-1:0];
  assign rd_addr_o = rd_next ? ptr_inc[AW-1:0] : ptr_q[AW-1:0];

  // sequencing of load, merge and finish
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    rd_next = 1'b0;
    dp_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (cmd_i == CMD_LOAD_A) begin
            if (cnt_q < CW'(MAX_ENTRIES)) begin
              dp_o.wr_en = 1'b1;
              cnt_d      = cnt_q + 1'b1;
            end else begin
              dp_o.set_ovf = 1'b1;
            end
          end else if (cmd_i == CMD_B_ITEM) begin
            if (ptr_q < cnt_q) begin
              dp_o.rd_en   = 1'b1;
              dp_o.latch_b = 1'b1;
              state_d      = ST_CMP;
            end
          end else if (cmd_i == CMD_FINISH) begin
            dp_o.latch_tot = 1'b1;
            state_d        = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CMP: begin
        priority if (sts_i.idx_lt) begin
          // skip a smaller A index, fetch the next one
          ptr_d = ptr_inc;
          if (ptr_inc < cnt_q) begin
            rd_next    = 1'b1;
            dp_o.rd_en = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.idx_eq) begin
          dp_o.mul_en = 1'b1;
          ptr_d       = ptr_inc;
          state_d     = ST_ACC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ACC: begin
        dp_o.acc_en = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_FIN: begin
        dp_o.diff_en = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        dp_o.out_en = 1'b1;
        dp_o.clear  = 1'b1;
        cnt_d       = '0;
        ptr_d       = '0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
    end
  end

  `SSD_ASSERT_IMP(ptr_within_count_a, 1'b1, ptr_q <= cnt_q, "merge pointer passed the count")
  `SSD_ASSERT_IMP(cnt_within_depth_a, 1'b1, cnt_q <= CW'(MAX_ENTRIES), "count above depth")
  `SSD_ASSERT_IMP(cmp_loaded_entry_a, state_q == ST_CMP, ptr_q < cnt_q, "compare on empty slot")
  `SSD_ASSERT_NXT(finish_clears_a, state_q == ST_OUT, (cnt_q == '0) && (ptr_q == '0), "no clear")
  `SSD_ASSERT_NXT(load_one_cycle_a, accept && (cmd_i == CMD_LOAD_A), state_q == ST_IDLE, "load busy")

endmodule

// ----- rtl/core/sparse_squared_distance.sv -----
// load A entry: taken while idle, busy stays low; B entry: busy stays low when the pointer
// is at the end, else busy through a compare state for each A entry visited and an accumulate
// state on a match (the read port steps one entry a cycle while smaller A indices are skipped)
// finish: busy in the difference and output states, then the registered done_o strobes
// the receiver cannot stall; async active-low reset clears count, pointer, sum and flag
// top level of the sparse squared distance block; depends on ssd_pkg, ssd_ctrl, ssd_datapath
`timescale 1ns / 1ps

module sparse_squared_distance #(
  parameter int unsigned MAX_ENTRIES = ssd_pkg::MaxEntriesDef,
  parameter int unsigned INDEX_BITS  = ssd_pkg::IndexBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ssd_pkg::ssd_req_t req_i,
  output logic              done_o,
  output ssd_pkg::ssd_rsp_t rsp_o
);
  import ssd_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  ssd_dp_cmd_t   dp_cmd;
  ssd_dp_sts_t   dp_sts;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // request decode and sequencing
  ssd_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (req_i.cmd),
    .busy_o   (busy),
    .sts_i    (dp_sts),
    .dp_o     (dp_cmd),
    .wr_addr_o(wr_addr),
    .rd_addr_o(rd_addr)
  );

  // buffer and arithmetic
  ssd_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (dp_cmd),
    .wr_addr_i(wr_addr),
    .rd_addr_i(rd_addr),
    .sts_o    (dp_sts),
    .done_o   (done_o),
    .rsp_o    (rsp_o)
  );

endmodule
